[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the equal-depth histogram table.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// A condition that holds in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// A condition that holds in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

[sv/edh_pkg.sv]
// Package of the equal-depth histogram table: widths, codes and shared types.
// Used by edh_bin_ram, edh_quota_div and equal_depth_histogram_table; no dependencies.
package edh_pkg;

  localparam int BIN_DEPTH = 64;
  localparam int BIN_AW    = 6;
  localparam int CNT_W     = 7;
  localparam int VAL_W     = 32;
  localparam int OCC_W     = 32;
  localparam int SUM_W     = 48;
  localparam int DIST_W    = 17;
  localparam int CFG_W     = 17;
  localparam int DIV_CW    = 5;

  localparam logic [DIST_W-1:0] MAX_DISTINCT = 17'd65536;
  localparam logic [CNT_W-1:0]  BIN_LIMIT    = 7'd64;
  localparam logic [SUM_W-1:0]  SUM_MAX      = '1;
  localparam logic [DIV_CW-1:0] DIV_STEPS    = 5'(DIST_W);

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_BINS  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_ABOVE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_LOADED  = 2'd0,
    STS_IGNORED = 2'd1,
    STS_FOUND   = 2'd2,
    STS_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DIV,
    FSM_LOAD,
    FSM_SRCH,
    FSM_READ
  } fsm_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic [SUM_W-1:0]        sum;
  } bin_entry_t;

  typedef struct packed {
    logic              we;
    logic [BIN_AW-1:0] waddr;
    bin_entry_t        wdata;
    logic [BIN_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_t                 status;
    logic [BIN_AW-1:0]       bin_id;
    logic signed [VAL_W-1:0] bin_low;
    logic signed [VAL_W-1:0] bin_high;
    logic [SUM_W-1:0]        bin_rows;
    logic [DIST_W-1:0]       bin_distinct;
    logic [SUM_W-1:0]        grand_total;
    logic [CNT_W-1:0]        bins_done;
  } result_t;

endpackage

[sv/edh_bin_ram.sv]
// Bin memory: one entry per bin with its smallest value, largest value and row sum.
// One write port and one read port with registered read data; uses edh_pkg.
module edh_bin_ram (
  input  logic                 clk,
  input  edh_pkg::ram_req_t    req,
  output edh_pkg::bin_entry_t  rd_data
);

  edh_pkg::bin_entry_t mem [edh_pkg::BIN_DEPTH];
  edh_pkg::bin_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/edh_quota_div.sv]
// Restoring divider that splits the distinct count into per-bin quota and remainder.
// Produces one quotient bit per cycle; uses edh_pkg.
module edh_quota_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [edh_pkg::DIST_W-1:0]   dividend,
  input  logic [edh_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [edh_pkg::DIST_W-1:0]   quotient,
  output logic [edh_pkg::CNT_W-1:0]    remainder
);

  logic [edh_pkg::DIST_W-1:0] quo_r, quo_nxt;
  logic [edh_pkg::CNT_W:0]    rem_r, rem_nxt;
  logic [edh_pkg::CNT_W-1:0]  div_r, div_nxt;
  logic [edh_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [edh_pkg::CNT_W:0]    trial;
  logic                       fits;

  assign trial = {rem_r[edh_pkg::CNT_W-1:0], quo_r[edh_pkg::DIST_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
      cnt_nxt = edh_pkg::DIV_STEPS;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? (trial - {1'b0, div_r}) : trial;
      quo_nxt = {quo_r[edh_pkg::DIST_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == edh_pkg::DIV_CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[edh_pkg::CNT_W-1:0];

endmodule

[sv/equal_depth_histogram_table.sv]
// Top level of the equal-depth histogram table: control, load path and bin search.
// Depends on edh_pkg, edh_bin_ram, edh_quota_div and assert_macros.svh.
//
// Usage: a transaction is taken at a rising edge with start high and busy low. Command
// load appends one sorted, distinct (value, count) pair; find and above search the
// finished bins. Every transaction gives exactly one result, shown for one cycle with
// out_valid high; the receiver has no way to hold it off, and none is needed.
// A load goes through the LOAD state, which registers its result. The first load
// after reset also runs the quota divider in the DIV state before LOAD.
// A query does a binary search over the finished bin maxima, one bin memory read per
// cycle, at most ceil(log2(bins_done + 1)) steps and never more than 7, plus one
// read of the chosen entry in the READ state; a search that runs past the last
// finished bin ends in SRCH without it. Ignored loads, the unused command and
// queries with no finished bin answer in the cycle after acceptance.
// A new transaction may be taken in the cycle a result is shown. The user is to write
// configuration through cfg_we, cfg_index and cfg_data only while busy is low; the
// block does not enforce this. Synchronous reset clears all counters, sets
// distinct_total to 1 and max_bins to 64; only finished bins hold valid bin memory.
`include "assert_macros.svh"

module equal_depth_histogram_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_command,
  input  logic signed [edh_pkg::VAL_W-1:0]   in_data_value,
  input  logic [edh_pkg::OCC_W-1:0]          in_occurrences,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [edh_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [edh_pkg::BIN_AW-1:0]         out_bin_id,
  output logic signed [edh_pkg::VAL_W-1:0]   out_bin_low,
  output logic signed [edh_pkg::VAL_W-1:0]   out_bin_high,
  output logic [edh_pkg::SUM_W-1:0]          out_bin_rows,
  output logic [edh_pkg::DIST_W-1:0]         out_bin_distinct,
  output logic [edh_pkg::SUM_W-1:0]          out_grand_total,
  output logic [edh_pkg::CNT_W-1:0]          out_bins_done
);

  function automatic logic [edh_pkg::SUM_W-1:0] sat_add(
    input logic [edh_pkg::SUM_W-1:0] a,
    input logic [edh_pkg::OCC_W-1:0] b
  );
    logic [edh_pkg::SUM_W:0] s;
    s = {1'b0, a} + (edh_pkg::SUM_W + 1)'(b);
    return s[edh_pkg::SUM_W] ? edh_pkg::SUM_MAX : s[edh_pkg::SUM_W-1:0];
  endfunction

  function automatic edh_pkg::result_t blank_result(
    input edh_pkg::status_t             s,
    input logic [edh_pkg::SUM_W-1:0]    total,
    input logic [edh_pkg::CNT_W-1:0]    done
  );
    edh_pkg::result_t r;
    r             = '0;
    r.status      = s;
    r.grand_total = total;
    r.bins_done   = done;
    return r;
  endfunction

  edh_pkg::fsm_t                   state_r, state_nxt;
  logic [edh_pkg::CFG_W-1:0]       cfg_total_r, cfg_total_nxt;
  logic [edh_pkg::CNT_W-1:0]       cfg_bins_r, cfg_bins_nxt;
  edh_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic signed [edh_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [edh_pkg::OCC_W-1:0]       occ_r, occ_nxt;
  logic [edh_pkg::CNT_W-1:0]       completed_r, completed_nxt;
  logic [edh_pkg::DIST_W-1:0]      pairs_r, pairs_nxt;
  logic [edh_pkg::DIST_W-1:0]      place_r, place_nxt;
  logic [edh_pkg::SUM_W-1:0]       running_r, running_nxt;
  logic [edh_pkg::SUM_W-1:0]       all_rows_r, all_rows_nxt;
  logic [edh_pkg::DIST_W-1:0]      quota_r, quota_nxt;
  logic [edh_pkg::CNT_W-1:0]       extra_r, extra_nxt;
  logic signed [edh_pkg::VAL_W-1:0] bin_low_r, bin_low_nxt;
  logic [edh_pkg::CNT_W-1:0]       lo_r, lo_nxt;
  logic [edh_pkg::CNT_W-1:0]       hi_r, hi_nxt;
  logic [edh_pkg::BIN_AW-1:0]      mid_r, mid_nxt;
  edh_pkg::result_t                res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;

  edh_pkg::cmd_t                   cmd_in;
  logic                            accept;
  logic [edh_pkg::DIST_W-1:0]      eff_total;
  logic [edh_pkg::CNT_W-1:0]       eff_bins;
  logic [edh_pkg::CNT_W-1:0]       div_n;
  logic                            load_ovf;
  logic [edh_pkg::DIST_W-1:0]      cur_width;
  logic [edh_pkg::DIST_W-1:0]      read_width;
  logic [edh_pkg::DIST_W-1:0]      place_inc;
  logic signed [edh_pkg::VAL_W-1:0] bin_low_cur;
  logic [edh_pkg::SUM_W-1:0]       run_sum;
  logic [edh_pkg::SUM_W-1:0]       all_sum;
  logic                            bin_full;
  logic                            go_right;
  logic [edh_pkg::CNT_W-1:0]       lo_step;
  logic [edh_pkg::CNT_W-1:0]       hi_step;
  logic [edh_pkg::CNT_W:0]         mid_sum;
  logic [edh_pkg::BIN_AW-1:0]      mid_step;
  logic [edh_pkg::BIN_AW-1:0]      first_mid;
  logic                            in_bin;
  logic                            found_out;

  edh_pkg::ram_req_t               ram_req;
  edh_pkg::bin_entry_t             rd_data;
  logic                            div_start;
  logic                            div_done;
  logic [edh_pkg::DIST_W-1:0]      div_quo;
  logic [edh_pkg::CNT_W-1:0]       div_rem;

  edh_bin_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  edh_quota_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (eff_total),
    .divisor   (div_n),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign busy   = (state_r != edh_pkg::FSM_IDLE);
  assign accept = start && !busy;
  assign cmd_in = edh_pkg::cmd_t'(in_command);

  assign eff_total = (cfg_total_r == '0) ? edh_pkg::DIST_W'(1) :
                     (cfg_total_r > edh_pkg::MAX_DISTINCT) ? edh_pkg::MAX_DISTINCT :
                     cfg_total_r;
  assign eff_bins  = (cfg_bins_r == '0) ? edh_pkg::CNT_W'(1) :
                     (cfg_bins_r > edh_pkg::BIN_LIMIT) ? edh_pkg::BIN_LIMIT : cfg_bins_r;
  assign div_n     = (eff_total < edh_pkg::DIST_W'(eff_bins)) ?
                     eff_total[edh_pkg::CNT_W-1:0] : eff_bins;
  assign load_ovf  = (pairs_r >= eff_total) || (completed_r >= edh_pkg::BIN_LIMIT);

  assign cur_width  = quota_r + edh_pkg::DIST_W'(completed_r < extra_r);
  assign read_width = quota_r + edh_pkg::DIST_W'(lo_r < extra_r);

  assign place_inc   = place_r + 1'b1;
  assign bin_low_cur = (place_r == '0) ? val_r : bin_low_r;
  assign run_sum     = sat_add(running_r, occ_r);
  assign all_sum     = sat_add(all_rows_r, occ_r);
  assign bin_full    = place_inc >= cur_width;

  assign go_right  = ($signed(rd_data.high) < $signed(val_r)) ||
                     ((cmd_r == edh_pkg::CMD_ABOVE) && (rd_data.high == val_r));
  assign lo_step   = go_right ? (edh_pkg::CNT_W'(mid_r) + 1'b1) : lo_r;
  assign hi_step   = go_right ? hi_r : edh_pkg::CNT_W'(mid_r);
  assign mid_sum   = {1'b0, lo_step} + {1'b0, hi_step};
  assign mid_step  = mid_sum[edh_pkg::BIN_AW:1];
  assign first_mid = completed_r[edh_pkg::CNT_W-1:1];
  assign in_bin    = ($signed(val_r) >= $signed(rd_data.low)) &&
                     ($signed(val_r) <= $signed(rd_data.high));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      edh_pkg::FSM_IDLE: begin
        if (accept) begin
          case (cmd_in)
            edh_pkg::CMD_LOAD: begin
              if (!load_ovf) begin
                state_nxt = (pairs_r == '0) ? edh_pkg::FSM_DIV : edh_pkg::FSM_LOAD;
              end
            end
            edh_pkg::CMD_FIND, edh_pkg::CMD_ABOVE: begin
              if (completed_r != '0) begin
                state_nxt = edh_pkg::FSM_SRCH;
              end
            end
            default: begin
              state_nxt = edh_pkg::FSM_IDLE;
            end
          endcase
        end
      end
      edh_pkg::FSM_DIV: begin
        if (div_done) begin
          state_nxt = edh_pkg::FSM_LOAD;
        end
      end
      edh_pkg::FSM_LOAD: begin
        state_nxt = edh_pkg::FSM_IDLE;
      end
      edh_pkg::FSM_SRCH: begin
        if (lo_step < hi_step) begin
          state_nxt = edh_pkg::FSM_SRCH;
        end else if (lo_step < completed_r) begin
          state_nxt = edh_pkg::FSM_READ;
        end else begin
          state_nxt = edh_pkg::FSM_IDLE;
        end
      end
      edh_pkg::FSM_READ: begin
        state_nxt = edh_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = edh_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    cfg_total_nxt = cfg_total_r;
    cfg_bins_nxt  = cfg_bins_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    occ_nxt       = occ_r;
    completed_nxt = completed_r;
    pairs_nxt     = pairs_r;
    place_nxt     = place_r;
    running_nxt   = running_r;
    all_rows_nxt  = all_rows_r;
    quota_nxt     = quota_r;
    extra_nxt     = extra_r;
    bin_low_nxt   = bin_low_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    div_start     = 1'b0;
    ram_req       = '0;

    if (cfg_we) begin
      case (cfg_index)
        edh_pkg::CFG_TOTAL: cfg_total_nxt = cfg_data;
        edh_pkg::CFG_BINS:  cfg_bins_nxt  = cfg_data[edh_pkg::CNT_W-1:0];
        default:            cfg_total_nxt = cfg_total_r;
      endcase
    end

    case (state_r)
      edh_pkg::FSM_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_in;
          val_nxt = in_data_value;
          occ_nxt = in_occurrences;
          case (cmd_in)
            edh_pkg::CMD_LOAD: begin
              if (load_ovf) begin
                res_nxt       = blank_result(edh_pkg::STS_IGNORED, all_rows_r, completed_r);
                out_valid_nxt = 1'b1;
              end else if (pairs_r == '0) begin
                div_start = 1'b1;
              end
            end
            edh_pkg::CMD_FIND, edh_pkg::CMD_ABOVE: begin
              if (completed_r == '0) begin
                res_nxt       = blank_result(edh_pkg::STS_MISSING, all_rows_r, completed_r);
                out_valid_nxt = 1'b1;
              end else begin
                lo_nxt        = '0;
                hi_nxt        = completed_r;
                mid_nxt       = first_mid;
                ram_req.raddr = first_mid;
              end
            end
            default: begin
              res_nxt       = blank_result(edh_pkg::STS_MISSING, all_rows_r, completed_r);
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      edh_pkg::FSM_DIV: begin
        if (div_done) begin
          quota_nxt = div_quo;
          extra_nxt = div_rem;
        end
      end
      edh_pkg::FSM_LOAD: begin
        pairs_nxt            = pairs_r + 1'b1;
        all_rows_nxt         = all_sum;
        res_nxt.status       = edh_pkg::STS_LOADED;
        res_nxt.bin_id       = completed_r[edh_pkg::BIN_AW-1:0];
        res_nxt.bin_low      = bin_low_cur;
        res_nxt.bin_high     = val_r;
        res_nxt.bin_rows     = run_sum;
        res_nxt.bin_distinct = place_inc;
        res_nxt.grand_total  = all_sum;
        out_valid_nxt        = 1'b1;
        if (bin_full) begin
          ram_req.we          = 1'b1;
          ram_req.waddr       = completed_r[edh_pkg::BIN_AW-1:0];
          ram_req.wdata.low   = bin_low_cur;
          ram_req.wdata.high  = val_r;
          ram_req.wdata.sum   = run_sum;
          completed_nxt       = completed_r + 1'b1;
          place_nxt           = '0;
          running_nxt         = '0;
          res_nxt.bins_done   = completed_r + 1'b1;
        end else begin
          place_nxt           = place_inc;
          running_nxt         = run_sum;
          bin_low_nxt         = bin_low_cur;
          res_nxt.bins_done   = completed_r;
        end
      end
      edh_pkg::FSM_SRCH: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step < hi_step) begin
          mid_nxt       = mid_step;
          ram_req.raddr = mid_step;
        end else if (lo_step < completed_r) begin
          ram_req.raddr = lo_step[edh_pkg::BIN_AW-1:0];
        end else begin
          res_nxt       = blank_result(edh_pkg::STS_MISSING, all_rows_r, completed_r);
          out_valid_nxt = 1'b1;
        end
      end
      edh_pkg::FSM_READ: begin
        out_valid_nxt = 1'b1;
        if ((cmd_r != edh_pkg::CMD_FIND) || in_bin) begin
          res_nxt.status       = edh_pkg::STS_FOUND;
          res_nxt.bin_id       = lo_r[edh_pkg::BIN_AW-1:0];
          res_nxt.bin_low      = rd_data.low;
          res_nxt.bin_high     = rd_data.high;
          res_nxt.bin_rows     = rd_data.sum;
          res_nxt.bin_distinct = read_width;
          res_nxt.grand_total  = all_rows_r;
          res_nxt.bins_done    = completed_r;
        end else begin
          res_nxt = blank_result(edh_pkg::STS_MISSING, all_rows_r, completed_r);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edh_pkg::FSM_IDLE;
      cfg_total_r <= edh_pkg::CFG_W'(1);
      cfg_bins_r  <= edh_pkg::BIN_LIMIT;
      completed_r <= '0;
      pairs_r     <= '0;
      place_r     <= '0;
      running_r   <= '0;
      all_rows_r  <= '0;
      quota_r     <= '0;
      extra_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_total_r <= cfg_total_nxt;
      cfg_bins_r  <= cfg_bins_nxt;
      completed_r <= completed_nxt;
      pairs_r     <= pairs_nxt;
      place_r     <= place_nxt;
      running_r   <= running_nxt;
      all_rows_r  <= all_rows_nxt;
      quota_r     <= quota_nxt;
      extra_r     <= extra_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    occ_r     <= occ_nxt;
    bin_low_r <= bin_low_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_bin_id       = res_r.bin_id;
  assign out_bin_low      = res_r.bin_low;
  assign out_bin_high     = res_r.bin_high;
  assign out_bin_rows     = res_r.bin_rows;
  assign out_bin_distinct = res_r.bin_distinct;
  assign out_grand_total  = res_r.grand_total;
  assign out_bins_done    = res_r.bins_done;

  assign found_out = out_valid && (out_status == edh_pkg::STS_FOUND);

  `ASSERT_ALWAYS(a_bins_bound, completed_r <= edh_pkg::BIN_LIMIT)
  `ASSERT_ALWAYS(a_place_bound, (place_r == '0) || (place_r < cur_width))
  `ASSERT_NEXT(a_item_tracked, start && !busy, busy || out_valid)
  `ASSERT_IMPLIES(a_found_in_range, found_out, edh_pkg::CNT_W'(out_bin_id) < out_bins_done)
  `ASSERT_IMPLIES(a_div_when_waiting, div_done, state_r == edh_pkg::FSM_DIV)

endmodule
